/* rtl/spmr_pkg.sv */
// shared types and constants of the spiral matrix readout unit
package spmr_pkg;

   // width of row, column and order fields
   localparam int unsigned FIELD_W = 4;
   // width of the element value on the stream ports
   localparam int unsigned DATA_W  = 16;

   // order register value after reset
   localparam logic [FIELD_W-1:0] ORDER_RESET = 4'd3;

   // request kinds carried on req_tuser
   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_FETCH = 1'b1
   } kind_type;

   // current spiral position and its flags
   typedef struct packed {
      logic [FIELD_W-1:0] row;
      logic [FIELD_W-1:0] col;
      logic               ring_done;
      logic               final_res;
   } spmr_pos_type;

endpackage

/* rtl/spiral_matrix_readout_unit.sv */
// Spiral matrix readout unit: holds a square matrix of odd order (set by the
// order register, even values rounded down) and returns its elements in
// counterclockwise spiral order from the bottom-right corner inwards, one per
// fetch transaction, with row, column, an end-of-ring flag on rsp_tuser and
// the centre element marked by rsp_tlast. Load transactions write one
// element when its row and column are in range, and always restart the walk;
// they give no result. A fetch result appears on the cycle after acceptance,
// that cycle being the registered read of the element store, whose read
// register also serves as the result register. A new transaction is taken
// every cycle while the result side drains. Fetch only elements that have
// been loaded since power-up.
module spiral_matrix_readout_unit
   import spmr_pkg::*;
#(
   parameter int unsigned MAX_ORDER   = 15,
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration channel
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata,   // [3:0] order, [7:4] zero
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [3:0] row, [7:4] col, [23:8] value
   input  logic        req_tuser,   // [0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] elem_value, [19:16] elem_row, [23:20] elem_col
   output logic        rsp_tuser,   // [0] ring_done
   output logic        rsp_tlast    // final_res
);

   localparam int unsigned DEPTH  = MAX_ORDER * MAX_ORDER;
   localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned MO_W   = $clog2(MAX_ORDER + 1);
   localparam int unsigned CW     = (MO_W > FIELD_W) ? MO_W : FIELD_W;

   logic [FIELD_W-1:0]        ld_row;
   logic [FIELD_W-1:0]        ld_col;
   logic [DATA_W-1:0]         ld_value;
   logic [VALUE_WIDTH+DATA_W-1:0] ld_ext;
   logic                      ld_in_range;
   logic                      req_accept;
   logic                      load_accept;
   logic                      fetch_accept;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;
   logic [VALUE_WIDTH-1:0]    rd_data;
   logic [VALUE_WIDTH+DATA_W-1:0] rd_ext;
   spmr_pos_type              pos;

   logic                      rsp_valid_ff,  rsp_valid_in;
   logic [FIELD_W-1:0]        rsp_row_ff,    rsp_row_in;
   logic [FIELD_W-1:0]        rsp_col_ff,    rsp_col_in;
   logic                      rsp_ring_ff,   rsp_ring_in;
   logic                      rsp_final_ff,  rsp_final_in;

   // request decode
   assign ld_row   = req_tdata[3:0];
   assign ld_col   = req_tdata[7:4];
   assign ld_value = req_tdata[23:8];

   assign csr_tready   = 1'b1;
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_accept   = req_tvalid && req_tready;
   assign load_accept  = req_accept && (kind_type'(req_tuser) == KIND_LOAD);
   assign fetch_accept = req_accept && (kind_type'(req_tuser) == KIND_FETCH);

   // load address, range check, sign extension into the store width, read address
   always_comb begin
      ld_in_range = (CW'(ld_row) < CW'(MAX_ORDER)) && (CW'(ld_col) < CW'(MAX_ORDER));
      wr_addr     = AW'(AW'(ld_row) * AW'(MAX_ORDER) + AW'(ld_col));
      ld_ext      = {{VALUE_WIDTH{ld_value[DATA_W-1]}}, ld_value};
      rd_addr     = AW'(AW'(pos.row) * AW'(MAX_ORDER) + AW'(pos.col));
   end

   // walk sequencer
   spmr_walk #(
      .MAX_ORDER (MAX_ORDER)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_tvalid && csr_tready),
      .csr_order (csr_tdata[3:0]),
      .restart   (load_accept),
      .step      (fetch_accept),
      .pos       (pos)
   );

   // element store, its read register holds the result value
   spmr_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_accept && ld_in_range),
      .wr_addr (wr_addr),
      .wr_data (ld_ext[VALUE_WIDTH-1:0]),
      .rd_en   (fetch_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register next values
   always_comb begin
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_ring_in  = rsp_ring_ff;
      rsp_final_in = rsp_final_ff;
      if (fetch_accept) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = pos.row;
         rsp_col_in   = pos.col;
         rsp_ring_in  = pos.ring_done;
         rsp_final_in = pos.final_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_ring_ff  <= rsp_ring_in;
      rsp_final_ff <= rsp_final_in;
   end

   // result value, zero above the store width
   assign rd_ext     = {{DATA_W{1'b0}}, rd_data};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff, rd_ext[DATA_W-1:0]};
   assign rsp_tuser  = rsp_ring_ff;
   assign rsp_tlast  = rsp_final_ff;

endmodule

/* rtl/spmr_ram.sv */
// generic single write port, single read port ram with registered read
module spmr_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 225
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/spmr_walk.sv */
// order register and spiral walk position sequencer
module spmr_walk
   import spmr_pkg::*;
#(
   parameter int unsigned MAX_ORDER = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr,
   input  logic [FIELD_W-1:0] csr_order,
   input  logic               restart,
   input  logic               step,
   output spmr_pos_type       pos
);

   // largest order the 4-bit register can reach within the store
   localparam logic [FIELD_W-1:0] MCAP =
      (MAX_ORDER > 15) ? 4'd15 : FIELD_W'(MAX_ORDER);

   logic [FIELD_W-1:0] order_ff,  order_in;
   logic [FIELD_W-1:0] row_ff,    row_in;
   logic [FIELD_W-1:0] col_ff,    col_in;
   logic [FIELD_W-1:0] ring_ff,   ring_in;

   logic [FIELD_W-1:0] m_last;
   logic [FIELD_W-1:0] new_last;
   logic [FIELD_W-1:0] hi;
   logic               centre;
   logic               ring_end;

   // effective order minus one: capped, zero to one, even rounded down
   function automatic logic [FIELD_W-1:0] last_index(input logic [FIELD_W-1:0] ord);
      logic [FIELD_W-1:0] cap;
      logic [FIELD_W-1:0] m;
      cap = (ord > MCAP) ? MCAP : ord;
      if (cap == '0) begin
         m = 4'd1;
      end else if (!cap[0]) begin
         m = cap - 4'd1;
      end else begin
         m = cap;
      end
      return m - 4'd1;
   endfunction

   // ring bounds and flags of the current position
   always_comb begin
      m_last   = last_index(order_ff);
      new_last = last_index(csr_order);
      hi       = (m_last >= ring_ff) ? (m_last - ring_ff) : ring_ff;
      centre   = (ring_ff >= hi);
      ring_end = !centre && (row_ff == hi) &&
                 ({1'b0, col_ff} + 5'd1 == {1'b0, hi});
   end

   assign pos.row       = row_ff;
   assign pos.col       = col_ff;
   assign pos.ring_done = ring_end;
   assign pos.final_res = centre;

   // next position
   always_comb begin
      order_in = order_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      ring_in  = ring_ff;
      priority if (csr_wr) begin
         order_in = csr_order;
         row_in   = new_last;
         col_in   = new_last;
         ring_in  = '0;
      end else if (restart) begin
         row_in  = m_last;
         col_in  = m_last;
         ring_in = '0;
      end else if (step) begin
         priority if (centre) begin
            row_in  = m_last;
            col_in  = m_last;
            ring_in = '0;
         end else if (ring_end) begin
            // step inward to the next ring's bottom-right corner
            ring_in = ring_ff + 4'd1;
            row_in  = hi - 4'd1;
            col_in  = hi - 4'd1;
         end else if (col_ff == hi && row_ff > ring_ff) begin
            row_in = row_ff - 4'd1;
         end else if (row_ff == ring_ff && col_ff > ring_ff) begin
            col_in = col_ff - 4'd1;
         end else if (col_ff == ring_ff && row_ff < hi) begin
            row_in = row_ff + 4'd1;
         end else if (row_ff == hi && col_ff < hi) begin
            col_in = col_ff + 4'd1;
         end else begin
            row_in  = m_last;
            col_in  = m_last;
            ring_in = '0;
         end
      end
   end

   // walk state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         row_ff   <= last_index(ORDER_RESET);
         col_ff   <= last_index(ORDER_RESET);
         ring_ff  <= '0;
      end else begin
         order_ff <= order_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         ring_ff  <= ring_in;
      end
   end

endmodule
